### design/mexp_pkg.sv
// Shared constants and types for the modular exponentiation block.
package mexp_pkg;

	// Operand width of base, exponent, modulus and result
	localparam int OPERAND_BITS = 31;

	// Stream payload widths, padded to whole bytes
	localparam int IN_DATA_W  = ((3 * OPERAND_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((OPERAND_BITS + 7) / 8) * 8;

	// Bit counter width for one pass over an operand
	localparam int CNT_W = $clog2(OPERAND_BITS);

	// Control for the bit-serial modular multiply-add unit
	typedef struct packed {
		logic clear;
		logic step;
	} mr_ctrl_t;

endpackage

### design/mexp_mulred.sv
// Bit-serial modular multiply-add step: acc = (2*acc + bit*a) mod m.
module mexp_mulred (
	input  logic                                clk,
	input  mexp_pkg::mr_ctrl_t                  ctrl,
	input  logic [mexp_pkg::OPERAND_BITS-1:0]   a,
	input  logic                                bit_in,
	input  logic [mexp_pkg::OPERAND_BITS-1:0]   m,
	input  logic [mexp_pkg::OPERAND_BITS:0]     m2,
	output logic [mexp_pkg::OPERAND_BITS-1:0]   acc
);

	localparam int W = mexp_pkg::OPERAND_BITS;

	logic [W-1:0] acc_q;
	logic [W+1:0] sum;
	logic [W+1:0] sub_m;
	logic [W+1:0] sub_m2;
	logic [W-1:0] next_acc;

	// Double and add; acc < m and a <= m keep the sum below 3m
	always_comb begin
		sum    = {1'b0, acc_q, 1'b0} + (bit_in ? {2'b00, a} : '0);
		sub_m  = sum - {2'b00, m};
		sub_m2 = sum - {1'b0, m2};
		if (sum >= {1'b0, m2}) begin
			next_acc = sub_m2[W-1:0];
		end else if (sum >= {2'b00, m}) begin
			next_acc = sub_m[W-1:0];
		end else begin
			next_acc = sum[W-1:0];
		end
	end

	// Accumulator
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.step) begin
			acc_q <= next_acc;
		end
	end

	assign acc = acc_q;

endmodule

### design/modular_exponentiation.sv
// Zero exponent or zero modulus skips the passes and goes straight to the done state.
// Otherwise the base is reduced first, then one square-and-multiply pass runs for each
// exponent bit up to the highest set one.
// One request is in work at a time, so a new request is taken only after the result is loaded;
// each product scans the square one bit a cycle, and a result may wait in the output register.
// Reset returns to idle with the output register empty.
module modular_exponentiation (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// base_value, exponent_value, modulus_value, zero pad
	input  logic [mexp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// power_residue, zero pad
	output logic [mexp_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

	localparam int W = mexp_pkg::OPERAND_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_NEXT = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]               state_q;
	logic [mexp_pkg::CNT_W-1:0] cnt_q;
	logic [W-1:0]             sr_q;
	logic [W-1:0]             exp_q;
	logic [W-1:0]             mod_q;
	logic [W:0]               mod2_q;
	logic [W-1:0]             sq_q;
	logic [W-1:0]             res_q;
	logic [W-1:0]             result_q;
	logic [W-1:0]             out_q;
	logic                     out_valid_q;

	logic [W-1:0]             in_base;
	logic [W-1:0]             in_exp;
	logic [W-1:0]             in_mod;
	logic [W-1:0]             sq_a;
	logic [W-1:0]             sq_acc;
	logic [W-1:0]             res_acc;
	logic                     out_load;
	mexp_pkg::mr_ctrl_t       ctl;

	assign in_base = s_axis_tdata[W-1:0];
	assign in_exp  = s_axis_tdata[2*W-1:W];
	assign in_mod  = s_axis_tdata[3*W-1:2*W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = mexp_pkg::OUT_DATA_W'(out_q);

	// Output register takes the result once it is free or being drained
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	// Unit control: clear before each pass, step during a pass
	always_comb begin
		ctl.clear = (state_q == ST_IDLE) || (state_q == ST_LOAD) || (state_q == ST_NEXT);
		ctl.step  = (state_q == ST_DIV) || (state_q == ST_MUL);
	end

	// Base reduction runs as a multiply by one; afterwards it squares
	assign sq_a = (state_q == ST_DIV) ? W'(1) : sq_q;

	mexp_mulred u_sq (
		.clk    (clk),
		.ctrl   (ctl),
		.a      (sq_a),
		.bit_in (sr_q[W-1]),
		.m      (mod_q),
		.m2     (mod2_q),
		.acc    (sq_acc)
	);

	mexp_mulred u_res (
		.clk    (clk),
		.ctrl   (ctl),
		.a      (res_q),
		.bit_in (sr_q[W-1]),
		.m      (mod_q),
		.m2     (mod2_q),
		.acc    (res_acc)
	);

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sr_q        <= '0;
			exp_q       <= '0;
			mod_q       <= '0;
			mod2_q      <= '0;
			sq_q        <= '0;
			res_q       <= '0;
			result_q    <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						exp_q  <= in_exp;
						mod_q  <= in_mod;
						mod2_q <= {in_mod, 1'b0};
						sr_q   <= in_base;
						res_q  <= W'(1);
						cnt_q  <= mexp_pkg::CNT_W'(W - 1);
						if (in_exp == '0) begin
							result_q <= W'(1);
							state_q  <= ST_DONE;
						end else if (in_mod == '0) begin
							result_q <= '0;
							state_q  <= ST_DONE;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					sr_q <= {sr_q[W-2:0], 1'b0};
					if (cnt_q == '0) begin
						state_q <= ST_LOAD;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_LOAD: begin
					sq_q    <= sq_acc;
					sr_q    <= sq_acc;
					cnt_q   <= mexp_pkg::CNT_W'(W - 1);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					sr_q <= {sr_q[W-2:0], 1'b0};
					if (cnt_q == '0) begin
						state_q <= ST_NEXT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_NEXT: begin
					if (exp_q[0]) begin
						res_q <= res_acc;
					end
					sq_q  <= sq_acc;
					sr_q  <= sq_acc;
					exp_q <= exp_q >> 1;
					cnt_q <= mexp_pkg::CNT_W'(W - 1);
					// Stop once no set exponent bit remains
					if ((exp_q >> 1) == '0) begin
						result_q <= exp_q[0] ? res_acc : res_q;
						state_q  <= ST_DONE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						out_q   <= result_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### verif/mexp_checker.sv
// Checker for modular_exponentiation: watches both streams, predicts residues, compares.
`timescale 1ns / 100ps

module mexp_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	// base_value, exponent_value, modulus_value, zero pad
	input  logic [mexp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// power_residue, zero pad
	input  logic [mexp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output int                              error_count,
	output int                              pending_count
);

	localparam int W = mexp_pkg::OPERAND_BITS;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic [W-1:0] base;
		logic [W-1:0] exponent;
		logic [W-1:0] modulus;
		logic [W-1:0] residue;
	} residue_req_t;

	residue_req_t residue_q[$];
	int errors = 0;
	int outstanding = 0;

	assign error_count   = errors;
	assign pending_count = outstanding;

	// (a * b) mod m by shift-and-add, one multiplier bit at a time from the top
	function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		logic [63:0] acc;
		acc = '0;
		for (int i = W - 1; i >= 0; i--) begin
			acc = acc + acc;
			if (acc >= m)
				acc = acc - m;
			if (b[i]) begin
				acc = acc + a;
				if (acc >= m)
					acc = acc - m;
			end
		end
		return acc;
	endfunction

	// Right-to-left square-and-multiply; zero exponent gives 1 unreduced
	function automatic logic [W-1:0] predict_residue(logic [W-1:0] b, logic [W-1:0] e,
			logic [W-1:0] m);
		logic [63:0] res;
		logic [63:0] sq;
		logic [63:0] mod64;
		if (e == '0)
			return W'(1);
		if (m == '0)
			return '0;
		mod64 = 64'(m);
		res = 64'd1;
		sq = 64'(b) % mod64;
		for (int i = 0; i < W; i++) begin
			if (e[i])
				res = mod_mul(res, sq, mod64);
			sq = mod_mul(sq, sq, mod64);
		end
		return res[W-1:0];
	endfunction

	// Results are checked before the same-edge request is queued
	always @(posedge clk) begin : monitor
		residue_req_t req;
		residue_req_t head;
		logic [W-1:0] got;
		int bad;
		bad = 0;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[W-1:0];
				if (residue_q.size() == 0) begin
					bad = 1;
					if (errors < MAX_REPORTS)
						$display("%0t: unexpected result residue %0d", $realtime, got);
				end else begin
					head = residue_q.pop_front();
					if (got !== head.residue) begin
						bad = 1;
						if (errors < MAX_REPORTS)
							$display("%0t: base %0d exp %0d mod %0d: expected %0d, got %0d",
								$realtime, head.base, head.exponent, head.modulus,
								head.residue, got);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				req.base     = s_axis_tdata[W-1:0];
				req.exponent = s_axis_tdata[2*W-1:W];
				req.modulus  = s_axis_tdata[3*W-1:2*W];
				req.residue  = predict_residue(req.base, req.exponent, req.modulus);
				residue_q = {residue_q, req};
			end
			errors <= errors + bad;
			outstanding <= residue_q.size();
		end
	end

endmodule

### verif/tb_modular_exponentiation.sv
// Testbench top for modular_exponentiation: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module tb_modular_exponentiation;

	localparam int W = mexp_pkg::OPERAND_BITS;
	localparam int RANDOM_ITEMS = 270;
	localparam int DRAIN_CYCLES = 1100;
	localparam logic [W-1:0] FULL = {W{1'b1}};

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [mexp_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [mexp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	int                              error_count;
	int                              pending_count;
	logic                            quiet = 1'b0;
	int                              stall_left = 0;

	modular_exponentiation u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	mexp_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.error_count   (error_count),
		.pending_count (pending_count)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(50, 200);
	endfunction

	function automatic logic [W-1:0] rand_operand();
		return W'($urandom);
	endfunction

	function automatic logic [W-1:0] rand_modulus();
		logic [W-1:0] m;
		m = rand_operand();
		return (m == '0) ? W'(1) : m;
	endfunction

	// Result side: random stalls unless in a quiet stretch
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 3) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= pick_gap();
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// One request: optional gap, then hold until accepted
	task automatic send_request(input logic [W-1:0] b, input logic [W-1:0] e,
			input logic [W-1:0] m);
		int gap;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(mexp_pkg::IN_DATA_W - 3 * W){1'b0}}, m, e, b};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Hold off new requests until every result is back
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
	endtask

	// Random request with a bias toward interesting operand shapes
	task automatic send_random_request();
		logic [W-1:0] b;
		logic [W-1:0] e;
		logic [W-1:0] m;
		int kind;
		kind = $urandom_range(0, 99);
		b = rand_operand();
		e = rand_operand();
		m = rand_modulus();
		if (kind < 40) begin
			// full random operands
		end else if (kind < 60) begin
			e = W'($urandom_range(0, 15));
		end else if (kind < 75) begin
			m = W'($urandom_range(1, 16));
		end else if (kind < 85) begin
			e = ($urandom_range(0, 7) == 0) ? '0 : (W'(1) << $urandom_range(0, W - 1));
		end else begin
			case ($urandom_range(0, 4))
				0: b = '0;
				1: b = W'(1);
				2: b = m;
				3: b = m - W'(1);
				default: b = FULL;
			endcase
		end
		send_request(b, e, m);
	endtask

	initial begin : stimulus
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes and special cases
		send_request('0, '0, W'(1));                   // zero exponent, modulus one
		send_request(W'(5), '0, W'(1));
		send_request(W'(5), W'(3), W'(1));              // modulus one, nonzero exponent
		send_request(W'(10), '0, FULL);                 // zero exponent, big modulus
		send_request(FULL, FULL, FULL);                 // all ones everywhere
		send_request(FULL, FULL, FULL - W'(1));
		send_request('0, W'(5), W'(7));                 // zero base
		send_request(W'(2), W'(10), W'(1000));
		send_request(W'(3), W'(1), FULL);
		send_request(FULL, W'(1), W'(13));              // base above modulus
		send_request(W'(2), W'(1) << (W - 1), FULL);    // only top exponent bit
		send_request(W'(123456789), FULL, W'(1000000007));
		send_request(W'(1), FULL, W'(2));
		send_request(FULL - W'(1), W'(2), FULL);
		send_request(W'(1000), W'(3), W'(7));
		send_request(W'(4), W'(13), W'(497));
		send_request(W'(31'h55555555), W'(31'h2AAAAAAA), W'(31'h55555555));
		send_request(W'(31'h2AAAAAAA), W'(31'h55555555), W'(31'h2AAAAAAA));
		send_request(FULL, W'(2), W'(2));
		send_request(W'(7), W'(1), W'(7));               // base equal to modulus
		drain_results();

		// Random part with a quiet stretch and a couple of full drains
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 100)
				quiet <= 1'b1;
			if (i == 140)
				quiet <= 1'b0;
			if (i == 160 || i == 230)
				drain_results();
			send_random_request();
		end
		s_axis_tvalid <= 1'b0;

		// Wait out every result, then some more for strays
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && pending_count == 0)
			$display("modular_exponentiation: match");
		else
			$display("modular_exponentiation: mismatch");
		$finish;
	end

	// Watchdog
	initial begin : watchdog
		#20_000_000;
		$display("modular_exponentiation: mismatch");
		$finish;
	end

endmodule
